@@ sv/bfg_pkg.sv @@
// ----------------------------------------------------------------------------
// bfg_pkg: shared types and constants of the bus frequency load governor
// Register indexes, field widths and the nominal mode windows.
// ----------------------------------------------------------------------------
package bfg_pkg;

  // default width of the free-running counters
  localparam int COUNTER_BITS_DEF = 32;

  // configuration and result field widths
  localparam int THR_W   = 41;
  localparam int DWELL_W = 16;
  localparam int GAIN_W  = 8;
  localparam int RAISE_W = 32;
  localparam int CFG_IDX_W = 2;

  // saturation values of the reported total and the dwell count
  localparam logic [THR_W-1:0] TOTAL_MAX = {THR_W{1'b1}};
  localparam logic [DWELL_W-1:0] DWELL_MAX = {DWELL_W{1'b1}};

  // nominal windows of the two bus modes
  localparam logic [31:0] HI_NOMINAL = 32'd600000000;
  localparam logic [31:0] HI_SPREAD  = 32'd60000000;
  localparam logic [31:0] LO_NOMINAL = 32'd100000000;
  localparam logic [31:0] LO_SPREAD  = 32'd30000000;

  // register reset values
  localparam logic [THR_W-1:0]   HIGH_THR_RST = 41'd30000000;
  localparam logic [THR_W-1:0]   LOW_THR_RST  = 41'd15000000;
  localparam logic [DWELL_W-1:0] DWELL_RST    = 16'd50;
  localparam logic [GAIN_W-1:0]  GAIN_RST     = 8'd10;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HIGH_THR   = 2'd0,
    REG_LOW_THR    = 2'd1,
    REG_DWELL_LIM  = 2'd2,
    REG_DELTA_GAIN = 2'd3
  } cfg_reg_t;

endpackage

@@ sv/bfg_if.sv @@
// ----------------------------------------------------------------------------
// bfg interfaces: sample, result and configuration channels
// Valid/ready channels; a transfer happens when valid and ready are high.
// ----------------------------------------------------------------------------

// sample channel: raw counter readings and current bus mode
interface bfg_in_if #(
  parameter int COUNTER_BITS = bfg_pkg::COUNTER_BITS_DEF
);
  logic                    valid;
  logic                    ready;
  logic [COUNTER_BITS-1:0] cycle_raw;
  logic [COUNTER_BITS-1:0] read_raw;
  logic [COUNTER_BITS-1:0] write_raw;
  logic                    bus_is_high;

  modport source (output valid, cycle_raw, read_raw, write_raw, bus_is_high, input ready);
  modport sink   (input valid, cycle_raw, read_raw, write_raw, bus_is_high, output ready);
endinterface

// result channel: one result per sample
interface bfg_out_if;
  logic                        valid;
  logic                        ready;
  logic                        sample_valid;
  logic                        request_high;
  logic                        raise_pulse;
  logic                        release_pulse;
  logic [bfg_pkg::THR_W-1:0]   rw_total;
  logic [bfg_pkg::RAISE_W-1:0] raise_count;

  modport source (output valid, sample_valid, request_high, raise_pulse, release_pulse,
                  rw_total, raise_count, input ready);
  modport sink   (input valid, sample_valid, request_high, raise_pulse, release_pulse,
                  rw_total, raise_count, output ready);
endinterface

// configuration write channel
interface bfg_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [bfg_pkg::CFG_IDX_W-1:0] index;
  logic [bfg_pkg::THR_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/bus_freq_load_governor.sv @@
// ----------------------------------------------------------------------------
// bus_freq_load_governor: load-based high bus frequency request
// Turns counter readings into deltas and drives a hysteresis request.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch   one sample per transfer: raw cycle, read and write counter
//           readings plus the current bus mode.
//   out_ch  one result per sample: plausibility flag, request state, raise
//           and release pulses, saturated read+write total, raise count.
//   cfg_ch  register writes (thresholds, dwell limit, gain); always ready;
//           the user writes only while no sample is in flight (unenforced).
// Timing: two register stages (sample register, result register). A result
//   is presented on out_ch from the result register, after its sample has
//   passed through the sample register and the datapath.
//   One sample per cycle is sustained unless out_ch stalls; the rate is set
//   by the single delta/multiply/compare pass between the two registers.
// Stall: when out_ch is not taken, the result register holds, the sample
//   register fills and in_ch.ready drops; nothing is lost.
// Reset: clears both stages, previous readings, request, dwell count and
//   raise count, and loads the register defaults.
// ----------------------------------------------------------------------------
module bus_freq_load_governor
  import bfg_pkg::*;
#(
  parameter int COUNTER_BITS = COUNTER_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  bfg_in_if.sink       in_ch,
  bfg_out_if.source    out_ch,
  bfg_cfg_if.sink      cfg_ch
);

  localparam int SCL_W = COUNTER_BITS + GAIN_W;
  localparam int SUM_W = SCL_W + 1;
  localparam int CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  // configuration registers
  logic [THR_W-1:0]   high_thr_r;
  logic [THR_W-1:0]   low_thr_r;
  logic [DWELL_W-1:0] dwell_lim_r;
  logic [GAIN_W-1:0]  gain_r;

  // sample stage
  logic                    s1_valid_r;
  logic [COUNTER_BITS-1:0] s1_cyc_r, s1_rd_r, s1_wr_r;
  logic                    s1_hi_r;
  logic                    s1_adv;

  // governor state
  logic [COUNTER_BITS-1:0] prev_cyc_r, prev_rd_r, prev_wr_r;
  logic                    req_r, req_nxt;
  logic [DWELL_W-1:0]      dwell_r, dwell_nxt;
  logic [RAISE_W-1:0]      raises_r, raises_nxt;

  // result register
  logic               out_valid_r;
  logic               res_valid_r, res_raise_r, res_release_r;
  logic [THR_W-1:0]   res_total_r;

  // combinational datapath
  logic [SCL_W-1:0]   dc, dr, dw;
  logic [CMP_W-1:0]   dc_x, total_x, hi_thr_x, lo_thr_x;
  logic               smp_ok, raised, released;
  logic               req_mid, in_between;
  logic [DWELL_W-1:0] dwell_inc;
  logic [THR_W-1:0]   total_sat;

  assign cfg_ch.ready = 1'b1;
  assign s1_adv       = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = !s1_valid_r || s1_adv;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      high_thr_r  <= HIGH_THR_RST;
      low_thr_r   <= LOW_THR_RST;
      dwell_lim_r <= DWELL_RST;
      gain_r      <= GAIN_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        REG_HIGH_THR:   high_thr_r  <= cfg_ch.data;
        REG_LOW_THR:    low_thr_r   <= cfg_ch.data;
        REG_DWELL_LIM:  dwell_lim_r <= cfg_ch.data[DWELL_W-1:0];
        REG_DELTA_GAIN: gain_r      <= cfg_ch.data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // sample register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.ready && in_ch.valid) begin
      s1_cyc_r <= in_ch.cycle_raw;
      s1_rd_r  <= in_ch.read_raw;
      s1_wr_r  <= in_ch.write_raw;
      s1_hi_r  <= in_ch.bus_is_high;
    end
  end

  // scaled deltas; a counter that did not move forward gives zero
  always_comb begin
    dc = (s1_cyc_r > prev_cyc_r) ?
         SCL_W'(s1_cyc_r - prev_cyc_r) * SCL_W'(gain_r) : '0;
    dr = (s1_rd_r > prev_rd_r) ?
         SCL_W'(s1_rd_r - prev_rd_r) * SCL_W'(gain_r) : '0;
    dw = (s1_wr_r > prev_wr_r) ?
         SCL_W'(s1_wr_r - prev_wr_r) * SCL_W'(gain_r) : '0;
  end

  // plausibility against the mode window
  always_comb begin
    dc_x     = CMP_W'(dc);
    total_x  = CMP_W'(SUM_W'(dr) + SUM_W'(dw));
    hi_thr_x = CMP_W'(high_thr_r);
    lo_thr_x = CMP_W'(low_thr_r);
    if (dc == '0 || dr == '0 || dw == '0) begin
      smp_ok = 1'b0;
    end else if (s1_hi_r) begin
      smp_ok = (dc_x >= CMP_W'(HI_NOMINAL - HI_SPREAD)) &&
               (dc_x <= CMP_W'(HI_NOMINAL + HI_SPREAD)) &&
               (total_x <= CMP_W'(HI_NOMINAL));
    end else begin
      smp_ok = (dc_x >= CMP_W'(LO_NOMINAL - LO_SPREAD)) &&
               (dc_x <= CMP_W'(LO_NOMINAL + LO_SPREAD)) &&
               (total_x <= CMP_W'(LO_NOMINAL));
    end
    total_sat = (total_x > CMP_W'(TOTAL_MAX)) ? TOTAL_MAX : total_x[THR_W-1:0];
  end

  // hysteresis and dwell
  always_comb begin
    raised     = 1'b0;
    released   = 1'b0;
    req_nxt    = req_r;
    dwell_nxt  = dwell_r;
    raises_nxt = raises_r;
    req_mid    = req_r;
    dwell_inc  = (dwell_r == DWELL_MAX) ? dwell_r : dwell_r + 1'b1;
    in_between = (total_x > lo_thr_x) && (total_x < hi_thr_x);
    if (smp_ok) begin
      if (!req_r && total_x > hi_thr_x) begin
        req_mid    = 1'b1;
        raised     = 1'b1;
        raises_nxt = raises_r + 1'b1;
      end else if (req_r && total_x < lo_thr_x) begin
        req_mid  = 1'b0;
        released = 1'b1;
      end
      req_nxt = req_mid;
      if (req_mid && in_between) begin
        if (dwell_inc >= dwell_lim_r) begin
          req_nxt   = 1'b0;
          released  = 1'b1;
          dwell_nxt = '0;
        end else begin
          dwell_nxt = dwell_inc;
        end
      end else begin
        dwell_nxt = '0;
      end
    end
  end

  // state update on each processed sample
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_cyc_r <= '0;
      prev_rd_r  <= '0;
      prev_wr_r  <= '0;
      req_r      <= 1'b0;
      dwell_r    <= '0;
      raises_r   <= '0;
    end else if (s1_adv && s1_valid_r) begin
      prev_cyc_r <= s1_cyc_r;
      prev_rd_r  <= s1_rd_r;
      prev_wr_r  <= s1_wr_r;
      req_r      <= req_nxt;
      dwell_r    <= dwell_nxt;
      raises_r   <= raises_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_valid_r) begin
      res_valid_r   <= smp_ok;
      res_raise_r   <= raised;
      res_release_r <= released;
      res_total_r   <= total_sat;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.sample_valid  = res_valid_r;
  assign out_ch.request_high  = req_r;
  assign out_ch.raise_pulse   = res_raise_r;
  assign out_ch.release_pulse = res_release_r;
  assign out_ch.rw_total      = res_total_r;
  assign out_ch.raise_count   = raises_r;

endmodule
